// ===== design/apr_pkg.sv =====
// Shared constants and types for the aging page replacement block.
package apr_pkg;

  localparam int PAGE_W      = 8;
  localparam int LIMIT_W     = 4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

  // request queue between front and back; power of two
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
  } apr_req_t;

endpackage

// ===== design/apr_front.sv =====
// Front end: request intake queue and frame limit register with clamping.
module apr_front #(
  parameter int MAX_FRAMES = 8,
  localparam int OCC_W = $clog2(MAX_FRAMES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [apr_pkg::PAGE_W-1:0]    page_id_i,
  input  logic                          cfg_we_i,
  input  logic [apr_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  output apr_pkg::apr_req_t             req_o,
  input  logic                          pop_i,
  output logic [OCC_W-1:0]              limit_o
);

  localparam int QPTR_W = (apr_pkg::QUEUE_DEPTH > 1) ? $clog2(apr_pkg::QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(apr_pkg::QUEUE_DEPTH + 1);

  logic [apr_pkg::PAGE_W-1:0] queue_q [apr_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0]          wptr_q, rptr_q;
  logic [QCNT_W-1:0]          count_q;
  logic [apr_pkg::LIMIT_W-1:0] limit_q;
  logic                       push, pop;

  assign in_ready_o = (count_q != QCNT_W'(apr_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != '0);

  assign req_o.valid = (count_q != '0);
  assign req_o.page  = queue_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
      limit_q <= apr_pkg::LIMIT_RESET;
    end else begin
      if (push) wptr_q <= wptr_q + QPTR_W'(1);
      if (pop)  rptr_q <= rptr_q + QPTR_W'(1);
      if (push && !pop)      count_q <= count_q + QCNT_W'(1);
      else if (pop && !push) count_q <= count_q - QCNT_W'(1);
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wptr_q] <= page_id_i;
  end

  // zero acts as one frame, anything above the frame count as the frame count
  always_comb begin
    if (limit_q == '0) begin
      limit_o = OCC_W'(1);
    end else if (32'(limit_q) > 32'(MAX_FRAMES)) begin
      limit_o = OCC_W'(MAX_FRAMES);
    end else begin
      limit_o = OCC_W'(limit_q);
    end
  end

endmodule

// ===== design/apr_back.sv =====
// Back end: lookup, victim scan, list update and result listing.
module apr_back #(
  parameter int MAX_FRAMES   = 8,
  parameter int HISTORY_BITS = 8,
  localparam int OCC_W = $clog2(MAX_FRAMES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  apr_pkg::apr_req_t          req_i,
  output logic                       pop_o,
  input  logic [OCC_W-1:0]           limit_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [apr_pkg::PAGE_W-1:0] resident_page_o,
  output logic                       fault_o,
  output logic                       last_o
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e                     st_q;
  logic [OCC_W-1:0]           occ_q, cnt_q;
  logic                       out_valid_q;

  logic [apr_pkg::PAGE_W-1:0] pages_q [MAX_FRAMES];
  logic [HISTORY_BITS-1:0]    hist_q  [MAX_FRAMES];
  logic [apr_pkg::PAGE_W-1:0] pages_d [MAX_FRAMES];
  logic [HISTORY_BITS-1:0]    hist_d  [MAX_FRAMES];

  logic [apr_pkg::PAGE_W-1:0] page_q;
  logic                       hit_q, evict_q;
  logic [IDX_W-1:0]           loc_q, victim_q;
  logic [HISTORY_BITS-1:0]    vhist_q;

  logic                       hit;
  logic [IDX_W-1:0]           loc;
  logic                       start, full, out_load, at_end;
  logic [IDX_W-1:0]           rd_idx;
  logic [HISTORY_BITS-1:0]    rd_hist;

  // parallel lookup, lowest position wins
  always_comb begin
    hit = 1'b0;
    loc = '0;
    for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
      if (OCC_W'(k) < occ_q && pages_q[k] == req_i.page) begin
        hit = 1'b1;
        loc = IDX_W'(k);
      end
    end
  end

  assign start    = (st_q == ST_IDLE) && req_i.valid;
  assign pop_o    = start;
  assign full     = (occ_q >= limit_i);
  assign rd_idx   = cnt_q[IDX_W-1:0];
  assign rd_hist  = hist_q[rd_idx];
  assign at_end   = (cnt_q == occ_q - OCC_W'(1));
  assign out_load = (st_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // new list: hit shifts in place; miss drops the victim if evicting and puts the page in front
  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      pages_d[k] = pages_q[k];
      hist_d[k]  = {1'b0, hist_q[k][HISTORY_BITS-1:1]};
      if (hit_q && IDX_W'(k) == loc_q) hist_d[k][HISTORY_BITS-1] = 1'b1;
    end
    if (!hit_q) begin
      pages_d[0] = page_q;
      hist_d[0]  = {1'b1, {(HISTORY_BITS-1){1'b0}}};
      for (int k = 1; k < MAX_FRAMES; k++) begin
        if (evict_q && !(IDX_W'(k - 1) < victim_q)) begin
          pages_d[k] = pages_q[k];
          hist_d[k]  = {1'b0, hist_q[k][HISTORY_BITS-1:1]};
        end else begin
          pages_d[k] = pages_q[k-1];
          hist_d[k]  = {1'b0, hist_q[k-1][HISTORY_BITS-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (start) begin
            cnt_q <= OCC_W'(1);
            if (!hit && full && occ_q > OCC_W'(1)) st_q <= ST_SCAN;
            else                                    st_q <= ST_UPDATE;
          end
        end
        ST_SCAN: begin
          if (at_end) st_q  <= ST_UPDATE;
          else        cnt_q <= cnt_q + OCC_W'(1);
        end
        ST_UPDATE: begin
          if (!hit_q && !evict_q) occ_q <= occ_q + OCC_W'(1);
          cnt_q <= '0;
          st_q  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            cnt_q <= cnt_q + OCC_W'(1);
            if (at_end) st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      page_q   <= req_i.page;
      hit_q    <= hit;
      loc_q    <= loc;
      evict_q  <= !hit && full;
      victim_q <= '0;
      vhist_q  <= hist_q[0];
    end
    // later position takes a tie
    if (st_q == ST_SCAN && rd_hist <= vhist_q) begin
      victim_q <= rd_idx;
      vhist_q  <= rd_hist;
    end
    if (st_q == ST_UPDATE) begin
      pages_q <= pages_d;
      hist_q  <= hist_d;
    end
    if (out_load) begin
      resident_page_o <= pages_q[rd_idx];
      fault_o         <= !hit_q;
      last_o          <= at_end;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= MAX_FRAMES)
    else $error("occupancy above frame count");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT) |-> (occ_q != '0))
    else $error("listing with empty frame list");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> (cnt_q < occ_q))
    else $error("victim scan past occupancy");

  a_evict_keeps_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_UPDATE && (hit_q || evict_q)) |=> (occ_q == $past(occ_q)))
    else $error("occupancy changed on hit or eviction");
`endif

endmodule

// ===== design/aging_page_replacement_core.sv =====
// Top level of the aging page replacement block.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   page_id_i
//   out      output     out_valid_o / out_ready_i resident_page_o, fault_o, last_o
//   cfg      input      cfg_we_i                  cfg_wdata_i (frame limit)
//
// Each request takes a lookup, a victim scan on a miss with a full list of more than
// one page, an update and a listing of every resident page. The listing rate is set
// by the single output register: one result per cycle while out_ready_i is high.
// A two-entry request queue accepts requests while the back end works.
// Reset (rst_ni low, async) empties the list and sets the frame limit to 3.
// Output stalls hold the listing; input stalls only when the queue is full.
module aging_page_replacement_core #(
  parameter int MAX_FRAMES   = 8,
  parameter int HISTORY_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [apr_pkg::PAGE_W-1:0]   page_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [apr_pkg::PAGE_W-1:0]   resident_page_o,
  output logic                         fault_o,
  output logic                         last_o,
  input  logic                         cfg_we_i,
  input  logic [apr_pkg::LIMIT_W-1:0]  cfg_wdata_i
);

  localparam int OCC_W = $clog2(MAX_FRAMES + 1);

  apr_pkg::apr_req_t req;
  logic              pop;
  logic [OCC_W-1:0]  limit;

  apr_front #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .page_id_i  (page_id_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_o      (req),
    .pop_i      (pop),
    .limit_o    (limit)
  );

  apr_back #(
    .MAX_FRAMES  (MAX_FRAMES),
    .HISTORY_BITS(HISTORY_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .pop_o          (pop),
    .limit_i        (limit),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .resident_page_o(resident_page_o),
    .fault_o        (fault_o),
    .last_o         (last_o)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for aging_page_replacement_core.

// Tracks the resident page list and holds the listings the block must produce.
class aging_scoreboard;
  localparam int FRAMES = 8;

  typedef struct packed {
    logic [apr_pkg::PAGE_W-1:0] page;
    logic                       fault;
    logic                       last;
  } listing_entry_t;

  logic [apr_pkg::PAGE_W-1:0]  pages [FRAMES];
  logic [7:0]                  hist  [FRAMES];
  int                          resident;
  logic [apr_pkg::LIMIT_W-1:0] frame_limit;
  listing_entry_t              expected_listing [$];
  int                          mismatches;

  function new();
    resident    = 0;
    frame_limit = apr_pkg::LIMIT_RESET;
    mismatches  = 0;
  endfunction

  function void set_limit(logic [apr_pkg::LIMIT_W-1:0] value);
    frame_limit = value;
  endfunction

  function int pending();
    return expected_listing.size();
  endfunction

  // Apply one page request and queue the full listing it produces.
  function void note_reference(logic [apr_pkg::PAGE_W-1:0] page);
    int             loc;
    int             victim;
    int             lim;
    bit             hit;
    listing_entry_t entry;
    loc = 0;
    hit = 1'b0;
    for (int k = 0; k < resident; k++) begin
      if (!hit && pages[k] == page) begin
        hit = 1'b1;
        loc = k;
      end
    end
    if (!hit) begin
      lim = int'(frame_limit);
      if (lim < 1) lim = 1;
      if (lim > FRAMES) lim = FRAMES;
      if (resident >= lim && resident > 0) begin
        // smallest history loses; ties go to the entry furthest back
        victim = 0;
        for (int k = 1; k < resident; k++) begin
          if (hist[k] <= hist[victim]) victim = k;
        end
        for (int k = victim; k + 1 < resident; k++) begin
          pages[k] = pages[k+1];
          hist[k]  = hist[k+1];
        end
        resident--;
      end
      for (int k = resident; k > 0; k--) begin
        pages[k] = pages[k-1];
        hist[k]  = hist[k-1];
      end
      pages[0] = page;
      hist[0]  = '0;
      resident++;
      loc = 0;
    end
    for (int k = 0; k < resident; k++) begin
      hist[k] = {(k == loc), hist[k][7:1]};
    end
    for (int k = 0; k < resident; k++) begin
      entry.page  = pages[k];
      entry.fault = !hit;
      entry.last  = (k + 1 == resident);
      expected_listing = {expected_listing, entry};
    end
  endfunction

  function void check_entry(logic [apr_pkg::PAGE_W-1:0] page, logic fault, logic last);
    listing_entry_t want;
    if (expected_listing.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: page=%02h fault=%b last=%b", page, fault, last);
      return;
    end
    want = expected_listing.pop_front();
    if (want.page !== page || want.fault !== fault || want.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp page=%02h fault=%b last=%b, got page=%02h fault=%b last=%b",
                 want.page, want.fault, want.last, page, fault, last);
    end
  endfunction
endclass

module tb_top;

  localparam int MAX_FRAMES   = 8;
  localparam int HISTORY_BITS = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [apr_pkg::PAGE_W-1:0]  page_id_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [apr_pkg::PAGE_W-1:0]  resident_page_o;
  logic                        fault_o;
  logic                        last_o;
  logic                        cfg_we_i    = 1'b0;
  logic [apr_pkg::LIMIT_W-1:0] cfg_wdata_i = '0;

  aging_scoreboard sb;
  int              stall_pct = 0;
  int              cycles    = 0;

  aging_page_replacement_core #(
    .MAX_FRAMES  (MAX_FRAMES),
    .HISTORY_BITS(HISTORY_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .page_id_i      (page_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .resident_page_o(resident_page_o),
    .fault_o        (fault_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: check on handshake, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_entry(resident_page_o, fault_o, last_o);
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Valid is only lowered when the sender idles; back-to-back requests keep it high.
  task automatic send_page(input logic [apr_pkg::PAGE_W-1:0] page, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    page_id_i  <= page;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_reference(page);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_frame_limit(input logic [apr_pkg::LIMIT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_limit(value);
  endtask

  // Mostly pages from a small working set so hits and evictions both happen.
  task automatic run_phase(input logic [apr_pkg::LIMIT_W-1:0] limit, input int snd_pct,
                           input int rcv_pct, input int count);
    logic [apr_pkg::PAGE_W-1:0] pool [12];
    int                         pool_n;
    int                         eff;
    logic [apr_pkg::PAGE_W-1:0] page;
    drain();
    write_frame_limit(limit);
    stall_pct = rcv_pct;
    eff = (limit < 1) ? 1 : (limit > MAX_FRAMES) ? MAX_FRAMES : int'(limit);
    pool_n = eff + int'($urandom_range(1, 3));
    for (int k = 0; k < pool_n; k++) pool[k] = apr_pkg::PAGE_W'($urandom_range(0, 255));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 75) page = pool[$urandom_range(0, pool_n - 1)];
      else page = apr_pkg::PAGE_W'($urandom_range(0, 255));
      send_page(page, snd_pct);
    end
  endtask

  initial begin
    logic [apr_pkg::PAGE_W-1:0] directed [$];
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limit of 3: fill, hit, evict, then starve two entries to force a history tie
    directed = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA};
    repeat (8) directed = {directed, 8'hAA};
    directed = {directed, 8'h33, 8'h0F, 8'hF0};
    foreach (directed[i]) send_page(directed[i], 0);

    run_phase(4'd0,  0,  0,  25);                    // zero limit acts as one frame
    run_phase(4'd8,  74, 0,  60);
    run_phase(4'd2,  0,  74, 50);                    // limit drops below occupancy
    run_phase(4'd15, 31, 31, 60);                    // above max clamps to max
    run_phase(4'($urandom_range(0, 15)), 0, 0, 50);
    run_phase(4'd4,  31, 31, 60);

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
